// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the noise filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CNF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cnf assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CNF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cnf assertion failed");

`endif

// ----- rtl/cnf_pkg.sv -----
// Types and fixed-point constants of the colored noise filter.
package cnf_pkg;

    typedef enum logic [1:0] {
        MODE_WHITE,
        MODE_PINK,
        MODE_BROWN,
        MODE_DEEP
    } noise_mode_t;

    localparam int FRAC      = 28;
    localparam int COEF_W    = FRAC + 1;
    localparam int IN_W      = 16;
    localparam int IN_SHIFT  = 13;
    localparam int MUL_CHUNK = 32;

    localparam int PINK_POLES = 6;
    localparam int PINK_IDX_W = $clog2(PINK_POLES);

    localparam logic signed [COEF_W-1:0] POLE_K [PINK_POLES] = '{
        29'sd268129440, 29'sd266642307, 29'sd260113957,
        29'sd232599323, 29'sd147639501, -29'sd204440443
    };
    localparam logic signed [COEF_W-1:0] FEED_K [PINK_POLES] = '{
        29'sd14902973, 29'sd20153033, 29'sd41299332,
        29'sd83345344, 29'sd143064478, -29'sd4536022
    };

    localparam logic signed [COEF_W-1:0] K_PINK_DIRECT = 29'sd143935092;
    localparam logic signed [COEF_W-1:0] K_PINK_DELAY  = 29'sd31118649;
    localparam logic signed [COEF_W-1:0] K_PINK_GAIN   = 29'sd14763950;
    localparam logic signed [COEF_W-1:0] K_LEAK        = 29'sd267630150;
    localparam logic signed [COEF_W-1:0] K_BROWN_IN    = 29'sd5368709;
    localparam logic signed [COEF_W-1:0] K_THREE_Q     = 29'sd201326592;
    localparam logic signed [COEF_W-1:0] K_HALF        = 29'sd134217728;
    localparam logic signed [COEF_W-1:0] K_DEEP_GAIN   = 29'sd38170;

endpackage

// ----- rtl/cnf_mulq.sv -----
// Shared multiplier: signed state value times Q28 coefficient, rounded, in 32-bit chunks.
module cnf_mulq #(
    parameter int STATE_WIDTH = 48
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [STATE_WIDTH-1:0]        a,
    input  logic signed [cnf_pkg::COEF_W-1:0]    c,
    output logic                                 done,
    output logic signed [STATE_WIDTH-1:0]        y
);

    localparam int CW     = cnf_pkg::MUL_CHUNK;
    localparam int NCHUNK = (STATE_WIDTH + CW - 1) / CW;
    localparam int MAGW   = NCHUNK * CW;
    localparam int ACCW   = MAGW + cnf_pkg::FRAC;
    localparam int CNT_W  = $clog2(NCHUNK + 2);
    localparam logic [ACCW-1:0] ROUND_HALF = ACCW'(1) << (cnf_pkg::FRAC - 1);

    logic                            busy_reg;
    logic [CNT_W-1:0]                cnt_reg;
    logic                            done_reg;
    logic                            neg_reg;
    logic [MAGW-1:0]                 ma_reg;
    logic [cnf_pkg::FRAC-1:0]        mc_reg;
    logic [ACCW-1:0]                 acc_reg;
    logic signed [STATE_WIDTH-1:0]   y_reg;

    logic [STATE_WIDTH-1:0]          a_abs;
    logic [cnf_pkg::COEF_W-1:0]      c_abs;
    logic [CW+cnf_pkg::FRAC-1:0]     part;
    logic [ACCW-1:0]                 acc_mac;
    logic [STATE_WIDTH-1:0]          mag;

    always_comb begin
        a_abs   = a[STATE_WIDTH-1] ? -a : a;
        c_abs   = c[cnf_pkg::COEF_W-1] ? -c : c;
        part    = ma_reg[MAGW-1 -: CW] * mc_reg;
        acc_mac = {acc_reg[ACCW-CW-1:0], {CW{1'b0}}} + ACCW'(part);
        mag     = acc_reg[cnf_pkg::FRAC +: STATE_WIDTH];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == CNT_W'(NCHUNK + 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= a[STATE_WIDTH-1] ^ c[cnf_pkg::COEF_W-1];
            ma_reg  <= MAGW'(a_abs);
            mc_reg  <= c_abs[cnf_pkg::FRAC-1:0];
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (cnt_reg < CNT_W'(NCHUNK)) begin
                acc_reg <= acc_mac;
                ma_reg  <= ma_reg << CW;
            end else if (cnt_reg == CNT_W'(NCHUNK)) begin
                acc_reg <= acc_reg + ROUND_HALF;
            end else begin
                y_reg <= neg_reg ? -mag : mag;
            end
        end
    end

    assign done = done_reg;
    assign y    = y_reg;

endmodule

// ----- rtl/cnf_pcm.sv -----
// Output stage: clamp to plus or minus one, scale to PCM full scale, round half to even.
module cnf_pcm #(
    parameter int STATE_WIDTH = 48,
    parameter int OUT_WIDTH   = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [STATE_WIDTH-1:0] s,
    output logic                          done,
    output logic [OUT_WIDTH-1:0]          pcm
);

    localparam int MW = cnf_pkg::FRAC + 1;
    localparam int PW = MW + OUT_WIDTH - 1;
    localparam logic signed [STATE_WIDTH-1:0] ONE_Q = STATE_WIDTH'(1) << cnf_pkg::FRAC;
    localparam logic [OUT_WIDTH-2:0] FULL_SCALE = '1;
    localparam logic [cnf_pkg::FRAC-1:0] HALF_Q = {1'b1, {(cnf_pkg::FRAC-1){1'b0}}};

    logic                      v1_reg;
    logic                      v2_reg;
    logic                      done_reg;
    logic                      neg1_reg;
    logic                      neg2_reg;
    logic [MW-1:0]             m1_reg;
    logic [PW-1:0]             p2_reg;
    logic [OUT_WIDTH-1:0]      pcm_reg;

    logic [STATE_WIDTH-1:0]    s_abs;
    logic [MW-1:0]             m_clamp;
    logic [OUT_WIDTH-1:0]      q;
    logic [cnf_pkg::FRAC-1:0]  r;
    logic                      up;
    logic [OUT_WIDTH-1:0]      q_round;

    always_comb begin
        s_abs = s[STATE_WIDTH-1] ? -s : s;
        if (s > ONE_Q || s < -ONE_Q) begin
            m_clamp = MW'(ONE_Q);
        end else begin
            m_clamp = s_abs[MW-1:0];
        end
        q       = p2_reg[cnf_pkg::FRAC +: OUT_WIDTH];
        r       = p2_reg[cnf_pkg::FRAC-1:0];
        up      = (r > HALF_Q) || (r == HALF_Q && q[0]);
        q_round = q + OUT_WIDTH'(up);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg1_reg <= s[STATE_WIDTH-1];
            m1_reg   <= m_clamp;
        end
        if (v1_reg) begin
            neg2_reg <= neg1_reg;
            p2_reg   <= PW'(m1_reg) * PW'(FULL_SCALE);
        end
        if (v2_reg) begin
            pcm_reg <= neg2_reg ? -q_round : q_round;
        end
    end

    assign done = done_reg;
    assign pcm  = pcm_reg;

endmodule

// ----- rtl/cnf_seq.sv -----
// Sequencer and filter state: drives the shared multiplier and adder for each mode.
module cnf_seq #(
    parameter int STATE_WIDTH = 48
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  cnf_pkg::noise_mode_t                mode,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [cnf_pkg::IN_W-1:0]            in_sample,
    output logic                                mul_start,
    output logic signed [STATE_WIDTH-1:0]       mul_a,
    output logic signed [cnf_pkg::COEF_W-1:0]   mul_c,
    input  logic                                mul_done,
    input  logic signed [STATE_WIDTH-1:0]       mul_y,
    output logic                                pcm_start,
    output logic signed [STATE_WIDTH-1:0]       pcm_s,
    input  logic                                pcm_done,
    input  logic                                out_free,
    output logic                                out_load
);

    localparam logic signed [STATE_WIDTH-1:0] SAT_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
    localparam logic signed [STATE_WIDTH-1:0] SAT_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WHITE,
        ST_PINK_POLE,
        ST_PINK_FEED,
        ST_PINK_SUM,
        ST_PINK_DLY,
        ST_PINK_DIR,
        ST_PINK_NEWDLY,
        ST_PINK_GAIN,
        ST_BROWN_LEAK,
        ST_BROWN_IN,
        ST_BROWN_OUT,
        ST_DEEP_1,
        ST_DEEP_2,
        ST_DEEP_3,
        ST_PCM,
        ST_WRITE
    } state_t;

    state_t                             state_reg;
    state_t                             state_next;
    logic                               enter_reg;
    logic [cnf_pkg::PINK_IDX_W-1:0]     idx_reg;
    logic                               idx_last;

    logic signed [STATE_WIDTH-1:0]      b_reg [cnf_pkg::PINK_POLES];
    logic signed [STATE_WIDTH-1:0]      dly_reg;
    logic signed [STATE_WIDTH-1:0]      brown_reg;
    logic signed [STATE_WIDTH-1:0]      deep1_reg;
    logic signed [STATE_WIDTH-1:0]      deep2_reg;
    logic signed [STATE_WIDTH-1:0]      w_reg;
    logic signed [STATE_WIDTH-1:0]      sum_reg;
    logic signed [STATE_WIDTH-1:0]      t_reg;
    logic signed [STATE_WIDTH-1:0]      s_reg;

    logic signed [STATE_WIDTH-1:0]      w_ext;
    logic signed [STATE_WIDTH-1:0]      add_a;
    logic signed [STATE_WIDTH-1:0]      add_b;
    logic signed [STATE_WIDTH-1:0]      add_y;
    logic                               mul_state;

    function automatic logic signed [STATE_WIDTH-1:0] add_sat(
        input logic signed [STATE_WIDTH-1:0] x,
        input logic signed [STATE_WIDTH-1:0] z
    );
        logic signed [STATE_WIDTH:0] total;
        total = {x[STATE_WIDTH-1], x} + {z[STATE_WIDTH-1], z};
        if (total[STATE_WIDTH] != total[STATE_WIDTH-1]) begin
            return total[STATE_WIDTH] ? SAT_MIN : SAT_MAX;
        end
        return total[STATE_WIDTH-1:0];
    endfunction

    always_comb begin
        w_ext     = STATE_WIDTH'($signed({in_sample, {cnf_pkg::IN_SHIFT{1'b0}}}));
        idx_last  = (idx_reg == cnf_pkg::PINK_IDX_W'(cnf_pkg::PINK_POLES - 1));
        mul_state = state_reg inside {ST_WHITE, ST_PINK_POLE, ST_PINK_FEED, ST_PINK_DIR,
                                      ST_PINK_NEWDLY, ST_PINK_GAIN, ST_BROWN_LEAK,
                                      ST_BROWN_IN, ST_BROWN_OUT, ST_DEEP_1, ST_DEEP_2,
                                      ST_DEEP_3};
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    case (mode)
                        cnf_pkg::MODE_WHITE: state_next = ST_WHITE;
                        cnf_pkg::MODE_PINK:  state_next = ST_PINK_POLE;
                        cnf_pkg::MODE_BROWN: state_next = ST_BROWN_LEAK;
                        cnf_pkg::MODE_DEEP:  state_next = ST_DEEP_1;
                        default:             state_next = ST_WHITE;
                    endcase
                end
            end
            ST_WHITE:       if (mul_done) state_next = ST_PCM;
            ST_PINK_POLE:   if (mul_done) state_next = ST_PINK_FEED;
            ST_PINK_FEED:   if (mul_done) state_next = ST_PINK_SUM;
            ST_PINK_SUM:    state_next = idx_last ? ST_PINK_DLY : ST_PINK_POLE;
            ST_PINK_DLY:    state_next = ST_PINK_DIR;
            ST_PINK_DIR:    if (mul_done) state_next = ST_PINK_NEWDLY;
            ST_PINK_NEWDLY: if (mul_done) state_next = ST_PINK_GAIN;
            ST_PINK_GAIN:   if (mul_done) state_next = ST_PCM;
            ST_BROWN_LEAK:  if (mul_done) state_next = ST_BROWN_IN;
            ST_BROWN_IN:    if (mul_done) state_next = ST_BROWN_OUT;
            ST_BROWN_OUT:   if (mul_done) state_next = ST_PCM;
            ST_DEEP_1:      if (mul_done) state_next = ST_DEEP_2;
            ST_DEEP_2:      if (mul_done) state_next = ST_DEEP_3;
            ST_DEEP_3:      if (mul_done) state_next = ST_PCM;
            ST_PCM:         if (pcm_done) state_next = ST_WRITE;
            ST_WRITE:       if (out_free) state_next = ST_IDLE;
            default:        state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        mul_a = w_reg;
        mul_c = cnf_pkg::K_HALF;
        add_a = sum_reg;
        add_b = mul_y;
        case (state_reg)
            ST_PINK_POLE: begin
                mul_a = b_reg[idx_reg];
                mul_c = cnf_pkg::POLE_K[idx_reg];
            end
            ST_PINK_FEED: begin
                mul_c = cnf_pkg::FEED_K[idx_reg];
                add_a = t_reg;
            end
            ST_PINK_SUM:    add_b = b_reg[idx_reg];
            ST_PINK_DLY:    add_b = dly_reg;
            ST_PINK_DIR:    mul_c = cnf_pkg::K_PINK_DIRECT;
            ST_PINK_NEWDLY: mul_c = cnf_pkg::K_PINK_DELAY;
            ST_PINK_GAIN: begin
                mul_a = sum_reg;
                mul_c = cnf_pkg::K_PINK_GAIN;
            end
            ST_BROWN_LEAK: begin
                mul_a = brown_reg;
                mul_c = cnf_pkg::K_LEAK;
            end
            ST_BROWN_IN: begin
                mul_c = cnf_pkg::K_BROWN_IN;
                add_a = t_reg;
            end
            ST_BROWN_OUT: begin
                mul_a = brown_reg;
                mul_c = cnf_pkg::K_THREE_Q;
                add_a = brown_reg;
            end
            ST_DEEP_1: begin
                mul_a = deep1_reg;
                mul_c = cnf_pkg::K_LEAK;
                add_a = w_reg;
            end
            ST_DEEP_2: begin
                mul_a = deep2_reg;
                mul_c = cnf_pkg::K_LEAK;
                add_a = deep1_reg;
            end
            ST_DEEP_3: begin
                mul_a = deep2_reg;
                mul_c = cnf_pkg::K_DEEP_GAIN;
            end
            default: begin
                mul_a = w_reg;
                mul_c = cnf_pkg::K_HALF;
            end
        endcase
        add_y = add_sat(add_a, add_b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            enter_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            enter_reg <= (state_next != state_reg);
            if (state_reg == ST_IDLE) begin
                idx_reg <= '0;
            end else if (state_reg == ST_PINK_SUM) begin
                idx_reg <= idx_last ? '0 : idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_reg     <= '{default: '0};
            dly_reg   <= '0;
            brown_reg <= '0;
            deep1_reg <= '0;
            deep2_reg <= '0;
        end else if (mul_done) begin
            case (state_reg)
                ST_PINK_FEED:   b_reg[idx_reg] <= add_y;
                ST_PINK_NEWDLY: dly_reg        <= mul_y;
                ST_BROWN_IN:    brown_reg      <= add_y;
                ST_DEEP_1:      deep1_reg      <= add_y;
                ST_DEEP_2:      deep2_reg      <= add_y;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    w_reg   <= w_ext;
                    sum_reg <= '0;
                end
            end
            ST_PINK_SUM, ST_PINK_DLY: sum_reg <= add_y;
            ST_PINK_DIR:   if (mul_done) sum_reg <= add_y;
            ST_PINK_POLE,
            ST_BROWN_LEAK: if (mul_done) t_reg <= mul_y;
            ST_BROWN_OUT:  if (mul_done) s_reg <= add_y;
            ST_WHITE,
            ST_PINK_GAIN,
            ST_DEEP_3:     if (mul_done) s_reg <= mul_y;
            default: ;
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign mul_start = enter_reg && mul_state;
    assign pcm_start = enter_reg && (state_reg == ST_PCM);
    assign pcm_s     = s_reg;
    assign out_load  = (state_reg == ST_WRITE) && out_free;

endmodule

// ----- rtl/colored_noise_filter.sv -----
// Top level of the colored noise filter: streams, mode register and output register.
//
//   Channel  Direction  Handshake          Carries
//   s_       in         s_tvalid/s_tready  white_sample, Q1.15
//   m_       out        m_tvalid/m_tready  pcm_sample, OUT_WIDTH bits
//   cfg_     in         cfg_valid/ready    noise_mode, 2 bits
//
// The products of a word go through the one shared multiplier one after another. Then
// come the output stage and the load of the output register, after which the sequencer
// returns to idle for the next input word.
// Reset clears all filter state and selects white mode.
// A finished word waits in the output register while the next input word is taken; a second
// finished word holds the input off until m_tready takes the first.
module colored_noise_filter #(
    parameter int OUT_WIDTH   = 16,
    parameter int STATE_WIDTH = 48
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [cnf_pkg::IN_W-1:0]             s_tdata,    // [15:0] white_sample
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((OUT_WIDTH+7)/8)*8-1:0]       m_tdata,    // [OUT_WIDTH-1:0] pcm_sample
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [1:0]                           cfg_data
);

    cnf_pkg::noise_mode_t                 mode_reg;
    logic                                 out_valid_reg;
    logic [OUT_WIDTH-1:0]                 out_data_reg;

    logic                                 mul_start;
    logic signed [STATE_WIDTH-1:0]        mul_a;
    logic signed [cnf_pkg::COEF_W-1:0]    mul_c;
    logic                                 mul_done;
    logic signed [STATE_WIDTH-1:0]        mul_y;
    logic                                 pcm_start;
    logic signed [STATE_WIDTH-1:0]        pcm_s;
    logic                                 pcm_done;
    logic [OUT_WIDTH-1:0]                 pcm_value;
    logic                                 out_free;
    logic                                 out_load;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= cnf_pkg::MODE_WHITE;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                mode_reg <= cnf_pkg::noise_mode_t'(cfg_data);
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= pcm_value;
        end
    end

    always_comb begin
        m_tdata                = '0;
        m_tdata[OUT_WIDTH-1:0] = out_data_reg;
    end

    assign m_tvalid = out_valid_reg;

    cnf_seq #(
        .STATE_WIDTH (STATE_WIDTH)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mode      (mode_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_sample (s_tdata),
        .mul_start (mul_start),
        .mul_a     (mul_a),
        .mul_c     (mul_c),
        .mul_done  (mul_done),
        .mul_y     (mul_y),
        .pcm_start (pcm_start),
        .pcm_s     (pcm_s),
        .pcm_done  (pcm_done),
        .out_free  (out_free),
        .out_load  (out_load)
    );

    cnf_mulq #(
        .STATE_WIDTH (STATE_WIDTH)
    ) u_mulq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .c       (mul_c),
        .done    (mul_done),
        .y       (mul_y)
    );

    cnf_pcm #(
        .STATE_WIDTH (STATE_WIDTH),
        .OUT_WIDTH   (OUT_WIDTH)
    ) u_pcm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (pcm_start),
        .s       (pcm_s),
        .done    (pcm_done),
        .pcm     (pcm_value)
    );

endmodule

// ----- rtl/cnf_checker.sv -----
// Port-level checker for the colored noise filter and its bind to the top level.
`include "assert_macros.svh"

module cnf_checker #(
    parameter int OUT_WIDTH = 16
) (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [((OUT_WIDTH+7)/8)*8-1:0]    m_tdata
);

    localparam logic [OUT_WIDTH-1:0] MOST_NEG = {1'b1, {(OUT_WIDTH-1){1'b0}}};

    `CNF_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `CNF_ASSERT_NEXT(a_no_instant_word, aclk, aresetn, s_tvalid && s_tready && !m_tvalid, !m_tvalid)
    `CNF_ASSERT_IMPL(a_pcm_symmetric, aclk, aresetn, m_tvalid, m_tdata[OUT_WIDTH-1:0] != MOST_NEG)
    `CNF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind colored_noise_filter cnf_checker #(
    .OUT_WIDTH (OUT_WIDTH)
) u_cnf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/noise_check_pkg.sv -----
// Bit-exact predictor and scoreboard for the PCM words of the colored noise filter.
`timescale 1ns / 100ps

package noise_check_pkg;

    import cnf_pkg::noise_mode_t;
    import cnf_pkg::MODE_WHITE;
    import cnf_pkg::MODE_PINK;
    import cnf_pkg::MODE_BROWN;
    import cnf_pkg::MODE_DEEP;

    localparam int     FRAC_BITS  = 28;
    localparam int     PINK_ORDER = 6;
    localparam longint STATE_MAX  = (64'sd1 <<< 47) - 64'sd1;
    localparam longint STATE_MIN  = -STATE_MAX - 64'sd1;
    localparam longint ONE_Q      = 64'sd1 <<< FRAC_BITS;
    localparam longint ROUND_HALF = 64'sd1 <<< (FRAC_BITS - 1);
    localparam longint FRAC_MASK  = ONE_Q - 64'sd1;
    localparam longint PCM_FULL   = 64'sd32767;

    localparam longint POLE_Q [PINK_ORDER] = '{
        268129440, 266642307, 260113957, 232599323, 147639501, -204440443
    };
    localparam longint FEED_Q [PINK_ORDER] = '{
        14902973, 20153033, 41299332, 83345344, 143064478, -4536022
    };
    localparam longint DIRECT_Q      = 143935092;
    localparam longint DELAY_Q       = 31118649;
    localparam longint PINK_GAIN_Q   = 14763950;
    localparam longint LEAK_Q        = 267630150;
    localparam longint BROWN_IN_Q    = 5368709;
    localparam longint BROWN_BOOST_Q = 201326592;
    localparam longint WHITE_GAIN_Q  = 134217728;
    localparam longint DEEP_GAIN_Q   = 38170;

    function automatic longint clamp_state(logic signed [127:0] x);
        if (x > STATE_MAX) return STATE_MAX;
        if (x < STATE_MIN) return STATE_MIN;
        return longint'(x);
    endfunction

    function automatic longint add_state(longint a, longint b);
        logic signed [127:0] t;
        t = a;
        t = t + b;
        return clamp_state(t);
    endfunction

    // Product rounded on its magnitude, so that ties go away from zero.
    function automatic longint scale_q(longint a, longint k);
        logic signed [127:0] prod;
        logic signed [127:0] mag;
        prod = a;
        prod = prod * k;
        mag  = (prod < 0) ? -prod : prod;
        mag  = (mag + ROUND_HALF) >>> FRAC_BITS;
        return clamp_state((prod < 0) ? -mag : mag);
    endfunction

    function automatic logic [15:0] quantise_pcm(longint s);
        longint m;
        longint p;
        longint q;
        longint r;
        logic   neg;
        neg = (s < 0);
        if (s > ONE_Q) s = ONE_Q;
        if (s < -ONE_Q) s = -ONE_Q;
        m = neg ? -s : s;
        p = m * PCM_FULL;
        q = p >>> FRAC_BITS;
        r = p & FRAC_MASK;
        if (r > ROUND_HALF || (r == ROUND_HALF && q[0])) q = q + 1;
        if (neg) q = -q;
        return q[15:0];
    endfunction

    class pcm_scoreboard;
        longint      pink_pole [PINK_ORDER];
        longint      pink_delay;
        longint      brown_acc;
        longint      deep_first;
        longint      deep_second;
        noise_mode_t mode = MODE_WHITE;
        logic [15:0] pcm_due [$];
        int          errors;

        function void set_mode(noise_mode_t m);
            mode = m;
        endfunction

        // Only the filter of the selected mode moves; the others keep their state.
        function logic [15:0] color_sample(logic [15:0] raw);
            longint w;
            longint s;
            longint sum;
            w = longint'($signed(raw)) * 64'sd8192;
            case (mode)
                MODE_PINK: begin
                    sum = 0;
                    for (int i = 0; i < PINK_ORDER; i++) begin
                        pink_pole[i] = add_state(scale_q(pink_pole[i], POLE_Q[i]),
                                                 scale_q(w, FEED_Q[i]));
                        sum = add_state(sum, pink_pole[i]);
                    end
                    sum = add_state(sum, pink_delay);
                    sum = add_state(sum, scale_q(w, DIRECT_Q));
                    pink_delay = scale_q(w, DELAY_Q);
                    s = scale_q(sum, PINK_GAIN_Q);
                end
                MODE_BROWN: begin
                    brown_acc = add_state(scale_q(brown_acc, LEAK_Q),
                                          scale_q(w, BROWN_IN_Q));
                    s = add_state(brown_acc, scale_q(brown_acc, BROWN_BOOST_Q));
                end
                MODE_DEEP: begin
                    deep_first  = add_state(scale_q(deep_first, LEAK_Q), w);
                    deep_second = add_state(scale_q(deep_second, LEAK_Q), deep_first);
                    s = scale_q(deep_second, DEEP_GAIN_Q);
                end
                default: begin
                    s = scale_q(w, WHITE_GAIN_Q);
                end
            endcase
            return quantise_pcm(s);
        endfunction

        function void note_sample(logic [15:0] raw);
            pcm_due.push_back(color_sample(raw));
        endfunction

        function void check_pcm(logic [15:0] got);
            logic [15:0] want;
            if (pcm_due.size() == 0) begin
                $display("%0t: unexpected pcm word, expected none, actual %0d",
                         $time, $signed(got));
                errors++;
                return;
            end
            want = pcm_due.pop_front();
            if (got !== want) begin
                $display("%0t: pcm mismatch, expected %0d, actual %0d",
                         $time, $signed(want), $signed(got));
                errors++;
            end
        endfunction
    endclass

endpackage

// ----- tb/tb_top.sv -----
// Top level of the colored noise filter testbench: clock, reset, stimulus and result checking.
`timescale 1ns / 100ps

module tb_top;

    import cnf_pkg::*;
    import noise_check_pkg::pcm_scoreboard;

    typedef enum int {
        STIM_UNIFORM,
        STIM_HELD,
        STIM_ONE_SIDED,
        STIM_SMALL,
        STIM_EXTREME
    } stim_style_t;

    localparam int TOTAL_WORDS   = 950;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 400;
    localparam int LIMIT_CYCLES  = 1000000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data  = '0;

    pcm_scoreboard board = new();
    int            sent;
    int            cycles;

    colored_noise_filter #(
        .OUT_WIDTH   (16),
        .STATE_WIDTH (48)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // The valid line is left high after a word so that back-to-back words need no toggle.
    task automatic send_word(input logic [15:0] smp, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        do @(posedge aclk); while (!s_tready);
        board.note_sample(smp);
        sent++;
    endtask

    task automatic drain_filter();
        s_tvalid <= 1'b0;
        while (board.pcm_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(input noise_mode_t m);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.set_mode(m);
    endtask

    function automatic logic [15:0] pick_sample(stim_style_t style, logic [15:0] level);
        logic [15:0] v;
        case (style)
            STIM_HELD: begin
                v = level;
            end
            STIM_ONE_SIDED: begin
                v = level[15] ? 16'($urandom_range(32768, 65535))
                              : 16'($urandom_range(0, 32767));
            end
            STIM_SMALL: begin
                v = 16'($urandom_range(0, 8)) - 16'd4;
            end
            STIM_EXTREME: begin
                v = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            end
            default: begin
                v = 16'($urandom);
            end
        endcase
        return v;
    endfunction

    initial begin
        logic [15:0] edge_words [6];
        noise_mode_t m;
        stim_style_t style;
        logic [15:0] level;
        int          len;
        bit          gappy;

        edge_words = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'hAAAA};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset leaves the filter in white mode, so the first pass needs no write.
        for (int k = 0; k < 4; k++) begin
            if (k != 0) begin
                drain_filter();
                write_mode(noise_mode_t'(k));
            end
            foreach (edge_words[i]) send_word(edge_words[i], $urandom_range(0, 3));
        end

        // A long run at full scale drives the deep filter into output saturation.
        drain_filter();
        write_mode(MODE_DEEP);
        repeat (140) send_word(16'h7FFF, $urandom_range(0, 1));

        while (sent < TOTAL_WORDS) begin
            m     = noise_mode_t'($urandom_range(0, 3));
            style = stim_style_t'($urandom_range(0, 4));
            level = $urandom_range(0, 2) == 0 ? 16'($urandom)
                  : ($urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
            len   = (style == STIM_HELD || style == STIM_ONE_SIDED)
                  ? $urandom_range(40, 120) : $urandom_range(15, 60);
            if (len > TOTAL_WORDS - sent) begin
                len = TOTAL_WORDS - sent;
            end
            gappy = $urandom_range(0, 3) != 0;
            drain_filter();
            write_mode(m);
            repeat (len) send_word(pick_sample(style, level), gappy ? $urandom_range(0, 3) : 0);
        end

        drain_filter();
        repeat (20) @(posedge aclk);
        if (board.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        int  taken;
        int  gap;
        int  calm_left;
        bit  calm;

        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (calm_left == 0) begin
                calm      = $urandom_range(0, 2) == 0;
                calm_left = $urandom_range(10, 50);
            end
            calm_left--;
            gap = calm ? 0 : $urandom_range(0, 3);
            if (taken == 150 || taken == 600) begin
                gap = LONG_HOLD;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            board.check_pcm(m_tdata[15:0]);
            taken++;
        end
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/cnf_pkg.sv
rtl/cnf_mulq.sv
rtl/cnf_pcm.sv
rtl/cnf_seq.sv
rtl/colored_noise_filter.sv
rtl/cnf_checker.sv
tb/noise_check_pkg.sv
tb/tb_top.sv
